@@ hdl/rltr_pkg.sv @@
`default_nettype none
package rltr_pkg;

    // Ring geometry
    localparam int BUFFER_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int PTR_W        = ADDR_W + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Register file
    localparam int RATE_W  = 16;
    localparam int BURST_W = 11;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST = 2'd1;
    localparam logic [RATE_W-1:0]    RATE_RESET  = 16'd2048;
    localparam logic [BURST_W-1:0]   BURST_RESET = 11'd256;

    // Field widths
    localparam int TOKEN_W = 11;
    localparam int FILL_W  = 11;
    localparam int ADD_W   = 13;

    // Divide by one million: q = (x * RECIP_M) >> RECIP_SHIFT, low by at most one
    localparam logic [31:0] US_PER_SECOND = 32'd1000000;
    localparam logic [24:0] RECIP_M       = 25'd17592186;
    localparam int          RECIP_SHIFT   = 44;

    // Command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;

    // Status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NO_TOKENS = 3'd1;
    localparam logic [2:0] STATUS_FULL      = 3'd2;
    localparam logic [2:0] STATUS_CUT       = 3'd3;
    localparam logic [2:0] STATUS_EMPTY     = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_us;
        logic [7:0]  data_byte;
    } rltr_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         tx_byte;
        logic               tx_valid;
        logic [TOKEN_W-1:0] tokens_left;
        logic [FILL_W-1:0]  fill_level;
    } rltr_out_t;

    typedef enum logic [1:0] {
        OP_REFILL,
        OP_BYTE,
        OP_DRAIN,
        OP_NONE
    } rltr_op_t;

    typedef struct packed {
        rltr_op_t    op;
        logic [31:0] now_us;
        logic [7:0]  data_byte;
    } rltr_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_RATE,
        BK_MUL_RECIP,
        BK_MUL_BACK,
        BK_REFILL,
        BK_READ
    } rltr_state_t;

endpackage
`default_nettype wire

@@ hdl/rltr_front.sv @@
`default_nettype none
module rltr_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rltr_pkg::rltr_in_t   s_data,
    output logic                      q_valid,
    input  wire logic                 q_pop,
    output rltr_pkg::rltr_entry_t     q_item
);
    import rltr_pkg::*;

    rltr_entry_t               entry;
    rltr_entry_t               q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]         count_reg, count_next;
    logic                      push;

    // Classify the incoming beat
    always_comb begin
        entry.now_us    = s_data.now_us;
        entry.data_byte = s_data.data_byte;
        case (s_data.command)
            CMD_START: entry.op = OP_REFILL;
            CMD_BYTE:  entry.op = OP_BYTE;
            CMD_DRAIN: entry.op = OP_DRAIN;
            default:   entry.op = OP_NONE;
        endcase
    end

    assign s_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];

    // Advance queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the classified beat
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

@@ hdl/rltr_back.sv @@
`default_nettype none
module rltr_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [rltr_pkg::RATE_W-1:0]    rate_i,
    input  wire logic [rltr_pkg::BURST_W-1:0]   burst_i,
    input  wire logic                           q_valid,
    output logic                                q_pop,
    input  wire rltr_pkg::rltr_entry_t          q_item,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output rltr_pkg::rltr_out_t                 m_data
);
    import rltr_pkg::*;

    rltr_state_t          state_reg, state_next;
    logic [TOKEN_W-1:0]   tokens_reg, tokens_next;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [31:0]          last_reg, last_next;
    logic                 cut_reg, cut_next;
    logic [31:0]          now_reg, now_next;
    logic [31:0]          elapsed_reg, elapsed_next;
    logic [31:0]          prod_reg, prod_next;
    logic [ADD_W-1:0]     qest_reg, qest_next;
    logic [31:0]          backp_reg, backp_next;
    logic                 m_valid_reg;
    rltr_out_t            m_data_reg;
    rltr_out_t            res;
    logic                 res_load;

    logic [7:0]           ring_mem [BUFFER_DEPTH];
    logic [7:0]           rdata_reg;
    logic                 mem_we, mem_re;

    logic                 out_free;
    logic [PTR_W-1:0]     fill_cur, fill_next;
    logic [47:0]          prod_full;
    logic [56:0]          recip_full;
    logic [32:0]          back_full;
    logic [31:0]          rem;
    logic [ADD_W-1:0]     add;
    logic [ADD_W:0]       sum;
    logic [2:0]           res_status;
    logic [7:0]           res_byte;
    logic                 res_txv;

    assign out_free = !m_valid_reg || m_ready;
    assign fill_cur = wr_ptr_reg - rd_ptr_reg;

    // Refill arithmetic, one multiplier per stage
    assign prod_full  = elapsed_reg * {16'd0, rate_i};
    assign recip_full = {25'd0, prod_reg} * {32'd0, RECIP_M};
    assign back_full  = {20'd0, qest_reg} * {1'b0, US_PER_SECOND};
    assign rem        = prod_reg - backp_reg;
    assign add        = qest_reg + ADD_W'(rem >= US_PER_SECOND);
    assign sum        = {1'b0, add} + (ADD_W+1)'(tokens_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    if (q_item.op == OP_REFILL && last_reg != '0) begin
                        state_next = BK_MUL_RATE;
                    end else if (q_item.op == OP_DRAIN && fill_cur != '0) begin
                        state_next = BK_READ;
                    end
                end
            end
            BK_MUL_RATE:  state_next = BK_MUL_RECIP;
            BK_MUL_RECIP: state_next = BK_MUL_BACK;
            BK_MUL_BACK:  state_next = BK_REFILL;
            BK_REFILL:    state_next = out_free ? BK_IDLE : BK_REFILL;
            BK_READ:      state_next = out_free ? BK_IDLE : BK_READ;
            default:      state_next = BK_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        res_load     = 1'b0;
        tokens_next  = tokens_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        last_next    = last_reg;
        cut_next     = cut_reg;
        now_next     = now_reg;
        elapsed_next = elapsed_reg;
        prod_next    = prod_reg;
        qest_next    = qest_reg;
        backp_next   = backp_reg;
        res_status   = STATUS_OK;
        res_byte     = '0;
        res_txv      = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    case (q_item.op)
                        OP_REFILL: begin
                            if (last_reg == '0) begin
                                if (out_free) begin
                                    q_pop       = 1'b1;
                                    res_load    = 1'b1;
                                    cut_next    = 1'b0;
                                    last_next   = q_item.now_us;
                                    tokens_next = burst_i;
                                end
                            end else begin
                                q_pop        = 1'b1;
                                cut_next     = 1'b0;
                                now_next     = q_item.now_us;
                                elapsed_next = q_item.now_us - last_reg;
                            end
                        end
                        OP_BYTE: begin
                            if (out_free) begin
                                q_pop    = 1'b1;
                                res_load = 1'b1;
                                if (cut_reg) begin
                                    res_status = STATUS_CUT;
                                end else if (tokens_reg == '0) begin
                                    res_status = STATUS_NO_TOKENS;
                                    cut_next   = 1'b1;
                                end else if (fill_cur >= PTR_W'(BUFFER_DEPTH)) begin
                                    res_status = STATUS_FULL;
                                    cut_next   = 1'b1;
                                end else begin
                                    mem_we      = 1'b1;
                                    wr_ptr_next = wr_ptr_reg + 1'b1;
                                    tokens_next = tokens_reg - 1'b1;
                                end
                            end
                        end
                        OP_DRAIN: begin
                            if (fill_cur == '0) begin
                                if (out_free) begin
                                    q_pop      = 1'b1;
                                    res_load   = 1'b1;
                                    res_status = STATUS_EMPTY;
                                end
                            end else begin
                                q_pop  = 1'b1;
                                mem_re = 1'b1;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                q_pop    = 1'b1;
                                res_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_MUL_RATE:  prod_next  = prod_full[31:0];
            BK_MUL_RECIP: qest_next  = recip_full[RECIP_SHIFT +: ADD_W];
            BK_MUL_BACK:  backp_next = back_full[31:0];
            BK_REFILL: begin
                if (out_free) begin
                    res_load = 1'b1;
                    if (add != '0) begin
                        last_next   = now_reg;
                        tokens_next = (sum > (ADD_W+1)'(burst_i)) ? burst_i : sum[TOKEN_W-1:0];
                    end
                end
            end
            BK_READ: begin
                if (out_free) begin
                    res_load    = 1'b1;
                    res_byte    = rdata_reg;
                    res_txv     = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
            end
            default: ;
        endcase
        fill_next       = wr_ptr_next - rd_ptr_next;
        res.status      = res_status;
        res.tx_byte     = res_byte;
        res.tx_valid    = res_txv;
        res.tokens_left = tokens_next;
        res.fill_level  = FILL_W'(fill_next);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            tokens_reg  <= BURST_RESET;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            last_reg    <= '0;
            cut_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tokens_reg <= tokens_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            last_reg   <= last_next;
            cut_reg    <= cut_next;
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        prod_reg    <= prod_next;
        qest_reg    <= qest_next;
        backp_reg   <= backp_next;
        if (res_load) begin
            m_data_reg <= res;
        end
    end

    // Ring storage, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_ptr_reg[ADDR_W-1:0]] <= q_item.data_byte;
        end
        if (mem_re) begin
            rdata_reg <= ring_mem[rd_ptr_reg[ADDR_W-1:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

@@ hdl/rate_limited_tx_ring_unit.sv @@
// Timing: a byte, empty-drain or unused beat, or a first refill, passes the front queue and
// is answered from the idle state; a drain that pops a byte first reads the ring memory;
// a timed refill first runs the three-stage multiply sequence for the divide by one million.
// Throughput: one byte item per cycle when m_ready allows; a read or refill blocks new items.
// Reset: aresetn is synchronous, active low; pointers, tokens (256), rate (2048),
// burst (256), refill time and message state clear; ring contents are not cleared.
`default_nettype none
module rate_limited_tx_ring_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire rltr_pkg::rltr_in_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output rltr_pkg::rltr_out_t                  m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rltr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rltr_pkg::CFG_W-1:0]      cfg_wdata
);
    import rltr_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               q_valid;
    logic               q_pop;
    rltr_entry_t        q_item;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg  <= RATE_RESET;
            burst_reg <= BURST_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_RATE) begin
                rate_reg <= cfg_wdata[RATE_W-1:0];
            end else if (cfg_index == REG_BURST) begin
                burst_reg <= cfg_wdata[BURST_W-1:0];
            end
        end
    end

    rltr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    rltr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rate_i  (rate_reg),
        .burst_i (burst_reg),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
